/* rtl/skvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

  localparam int CAPACITY = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
  } out_item_t;

  // Broadcast to every cell during the update cycle.
  typedef struct packed {
    logic       exec;
    logic [1:0] op;
    logic       hit;
    logic       full;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sorted_key_value_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload     Handshake
// in_      input      in_item_t   in_valid / in_stall
// out_     output     out_item_t  out_valid / out_stall
//
// For each item, every cell compares its key with the incoming key in the cycle
// of its transfer; when the update is allowed, the cells shift or update in
// parallel while the result register loads.
// The input stalls from a transfer until its result is written; the update
// waits while a previous result is held by out_stall.
// Reset (rst_n low, synchronous) empties the table and drops any pending item.

module sorted_key_value_table
  import skvt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic               cmd_valid_r;
  in_item_t           cmd_r;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               in_xfer;
  logic               exec;
  logic               hit;
  logic               full;
  logic signed [31:0] hit_value;
  cell_ctrl_t         ctrl;
  out_item_t          res;

  logic [CAPACITY-1:0]     valid_v;
  logic [CAPACITY-1:0]     less_v;
  logic [CAPACITY-1:0]     eq_v;
  logic signed [31:0]      key_a   [CAPACITY];
  logic signed [31:0]      value_a [CAPACITY];

  assign in_stall = cmd_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign exec     = cmd_valid_r && (!out_valid_r || !out_stall);

  assign hit  = |eq_v;
  assign full = valid_v[CAPACITY-1];

  assign ctrl.exec = exec;
  assign ctrl.op   = cmd_r.op;
  assign ctrl.hit  = hit;
  assign ctrl.full = full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               l_less;
    logic               l_valid;
    logic signed [31:0] l_key;
    logic signed [31:0] l_value;
    logic               r_valid;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;

    if (i == 0) begin : g_first
      assign l_less  = 1'b1;
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_value = '0;
    end else begin : g_mid_l
      assign l_less  = less_v[i-1];
      assign l_valid = valid_v[i-1];
      assign l_key   = key_a[i-1];
      assign l_value = value_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_value = '0;
    end else begin : g_mid_r
      assign r_valid = valid_v[i+1];
      assign r_key   = key_a[i+1];
      assign r_value = value_a[i+1];
    end

    skvt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmp_en      (in_xfer),
      .cmp_item    (in_data),
      .cmd_item    (cmd_r),
      .ctrl        (ctrl),
      .left_less   (l_less),
      .left_valid  (l_valid),
      .left_key    (l_key),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_key   (r_key),
      .right_value (r_value),
      .valid       (valid_v[i]),
      .key         (key_a[i]),
      .value       (value_a[i]),
      .less        (less_v[i]),
      .eq          (eq_v[i])
    );
  end

  // Keys are unique, so at most one cell matches and an OR selects its value.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (eq_v[i] ? value_a[i] : 32'sd0);
    end
  end

  always_comb begin
    res.status    = ST_DONE;
    res.value_out = '0;
    unique case (cmd_r.op)
      OP_INSERT: begin
        if (!hit && full) begin
          res.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          res.status = ST_ABSENT;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.value_out = hit_value;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        cmd_valid_r <= 1'b1;
      end else if (exec) begin
        cmd_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_data;
    end
    if (exec) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stored keys are distinct, so a compare never matches two cells.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_v))
    else $error("more than one cell matched the key");

  // Occupied cells form an unbroken run from the first cell.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_v & ~{valid_v[CAPACITY-2:0], 1'b1}) == '0)
    else $error("gap in occupied cells");

  // A value is reported only with a successful lookup.
  a_value_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.value_out == '0 || out_data.status == ST_DONE))
    else $error("value reported with failing status");

  // A refused insert leaves the table full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    exec && res.status == ST_FULL |=> valid_v[CAPACITY-1])
    else $error("full status with free cell");

endmodule

`default_nettype wire

/* rtl/skvt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmp_en,
  input  wire in_item_t           cmp_item,
  input  wire in_item_t           cmd_item,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               left_less,
  input  wire logic               left_valid,
  input  wire logic signed [31:0] left_key,
  input  wire logic signed [31:0] left_value,
  input  wire logic               right_valid,
  input  wire logic signed [31:0] right_key,
  input  wire logic signed [31:0] right_value,
  output logic                    valid,
  output logic signed [31:0]      key,
  output logic signed [31:0]      value,
  output logic                    less,
  output logic                    eq
);

  logic               valid_r;
  logic               valid_nxt;
  logic signed [31:0] key_r;
  logic signed [31:0] key_nxt;
  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;
  logic               less_r;
  logic               eq_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (ctrl.hit) begin
          if (eq_r) begin
            value_nxt = cmd_item.value_in;
          end
        end else if (!ctrl.full && !less_r) begin
          // The first cell not below the key takes the new pair; the ones
          // after it take their left neighbor's contents.
          if (left_less) begin
            valid_nxt = 1'b1;
            key_nxt   = cmd_item.key;
            value_nxt = cmd_item.value_in;
          end else begin
            valid_nxt = left_valid;
            key_nxt   = left_key;
            value_nxt = left_value;
          end
        end
      end
      OP_REMOVE: begin
        if (ctrl.hit && !less_r) begin
          valid_nxt = right_valid;
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      OP_LOOKUP: begin
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      less_r  <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      if (cmp_en) begin
        less_r <= valid_r && (key_r < cmp_item.key);
        eq_r   <= valid_r && (key_r == cmp_item.key);
      end
      if (ctrl.exec) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;
  assign less  = less_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import skvt_pkg::*;

  localparam int POOL_SIZE    = 96;
  localparam int RANDOM_ITEMS = 1525;
  localparam int MAX_WAIT     = 17;
  localparam int HOLD_CYCLES  = 500;

  // Idle behavior of one side of the block.
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_LIGHT = 2;

  // Operation mixes of the random segments.
  localparam int MIX_FILL    = 0;
  localparam int MIX_DRAIN   = 1;
  localparam int MIX_LOOKUP  = 2;
  localparam int MIX_BALANCE = 3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sorted_key_value_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table, updated in transfer order.
  logic signed [31:0] shadow_key [CAPACITY];
  logic signed [31:0] shadow_val [CAPACITY];
  int                 shadow_count = 0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  logic [31:0] key_pool [POOL_SIZE];

  int mismatches = 0;
  int items_sent = 0;
  int send_mode  = IDLE_NONE;
  int recv_mode  = IDLE_NONE;
  bit hold_off   = 1'b0;
  int in_gap     = 0;
  int out_wait   = 0;

  function automatic int draw_wait(int mode);
    if (mode == IDLE_NONE) return 0;
    if (mode == IDLE_FULL) return $urandom_range(0, MAX_WAIT);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t r;
    int        pos;
    bit        hit;
    r.status    = ST_DONE;
    r.value_out = '0;
    if (it.op == OP_CLEAR) begin
      shadow_count = 0;
    end else begin
      pos = 0;
      while (pos < shadow_count && $signed(shadow_key[pos]) < $signed(it.key)) pos++;
      hit = (pos < shadow_count) && (shadow_key[pos] == it.key);
      if (it.op == OP_INSERT) begin
        if (hit) begin
          shadow_val[pos] = it.value_in;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_val[i] = shadow_val[i-1];
          end
          shadow_key[pos] = it.key;
          shadow_val[pos] = it.value_in;
          shadow_count++;
        end
      end else if (it.op == OP_REMOVE) begin
        if (hit) begin
          for (int i = pos; i < shadow_count - 1; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_val[i] = shadow_val[i+1];
          end
          shadow_count--;
        end else begin
          r.status = ST_ABSENT;
        end
      end else begin
        if (hit) r.value_out = shadow_val[pos];
        else r.status = ST_ABSENT;
      end
    end
    return r;
  endfunction

  // Driver: presents queued items, predicts each one at its transfer.
  always @(posedge clk) begin : drive_proc
    logic     valid_n;
    in_item_t data_n;
    int       gap_n;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      valid_n = in_valid;
      data_n  = in_data;
      gap_n   = in_gap;
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_table_op(in_data));
        items_sent++;
        valid_n = 1'b0;
        gap_n   = draw_wait(send_mode);
      end
      if (!valid_n) begin
        if (gap_n > 0) begin
          gap_n--;
        end else if (pending_items.size() > 0) begin
          data_n  = pending_items.pop_front();
          valid_n = 1'b1;
        end
      end
      in_valid <= valid_n;
      in_data  <= data_n;
      in_gap   <= gap_n;
    end
  end

  // Monitor: checks every result transfer against the oldest prediction.
  always @(posedge clk) begin : monitor_proc
    out_item_t want;
    int        wait_n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else begin
      wait_n = out_wait;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                   $time, out_data.status, $signed(out_data.value_out));
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
            mismatches++;
          end
          if (out_data.value_out !== want.value_out) begin
            $display("%0t: value_out expected %0d actual %0d",
                     $time, $signed(want.value_out), $signed(out_data.value_out));
            mismatches++;
          end
        end
        wait_n = draw_wait(recv_mode);
      end else if (wait_n > 0) begin
        wait_n--;
      end
      out_wait  <= wait_n;
      out_stall <= hold_off || (wait_n > 0);
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    wait (items_sent >= 400);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic queue_item(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    in_item_t it;
    it.op       = op;
    it.key      = key;
    it.value_in = value;
    while (pending_items.size() >= 8) @(negedge clk);
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h8000_0000;
    if (r < 10) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [1:0] rand_op(int mix);
    int r;
    int lim_ins;
    int lim_rem;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin lim_ins = 70; lim_rem = 80; end
      MIX_DRAIN:  begin lim_ins = 25; lim_rem = 75; end
      MIX_LOOKUP: begin lim_ins = 30; lim_rem = 45; end
      default:    begin lim_ins = 40; lim_rem = 70; end
    endcase
    if (r < lim_ins) return OP_INSERT;
    if (r < lim_rem) return OP_REMOVE;
    if (r < 98) return OP_LOOKUP;
    return OP_CLEAR;
  endfunction

  initial begin : stimulus
    int sent;
    int seg;
    int idx;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = ($urandom & 32'hFFFF_FF00) | i;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty table, extreme keys and values, update, absent keys, clear.
    send_mode = IDLE_LIGHT;
    recv_mode = IDLE_LIGHT;
    queue_item(OP_LOOKUP, 32'd5, 32'd0);
    queue_item(OP_REMOVE, 32'd5, 32'd0);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_item(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    queue_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(OP_INSERT, 32'h0000_0001, 32'd12345);
    queue_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'd0);
    queue_item(OP_LOOKUP, 32'h8000_0000, 32'd0);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
    queue_item(OP_LOOKUP, 32'h0000_0000, 32'd0);
    queue_item(OP_LOOKUP, 32'h0000_0002, 32'd0);
    queue_item(OP_REMOVE, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_item(OP_REMOVE, 32'h0000_0001, 32'd0);
    queue_item(OP_LOOKUP, 32'h0000_0001, 32'd0);
    queue_item(OP_REMOVE, 32'h8000_0000, 32'd0);
    queue_item(OP_REMOVE, 32'h7FFF_FFFF, 32'd0);
    queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    queue_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(OP_LOOKUP, 32'h0000_0000, 32'd0);
    queue_item(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
    queue_item(OP_INSERT, 32'h7FFF_FFFE, 32'd1);
    queue_item(OP_CLEAR, 32'd0, 32'd0);

    // Fill past capacity with distinct keys, then work on the full table.
    sent = 0;
    send_mode = IDLE_NONE;
    recv_mode = IDLE_NONE;
    for (int i = 0; i < 70; i++) begin
      idx = (i * 37) % 70;
      queue_item(OP_INSERT, key_pool[idx], rand_value());
      sent++;
    end
    send_mode = IDLE_FULL;
    recv_mode = IDLE_LIGHT;
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0: queue_item(OP_INSERT, $urandom, rand_value());
        1: queue_item(OP_INSERT, key_pool[$urandom_range(0, 69)], rand_value());
        2: queue_item(OP_LOOKUP, key_pool[$urandom_range(0, 79)], $urandom);
        default: queue_item(OP_INSERT, key_pool[$urandom_range(70, POOL_SIZE - 1)],
                            rand_value());
      endcase
      sent++;
    end
    send_mode = IDLE_LIGHT;
    recv_mode = IDLE_FULL;
    for (int i = 0; i < 80; i++) begin
      idx = (i * 23) % 80;
      queue_item(OP_REMOVE, key_pool[idx], $urandom);
      sent++;
    end

    // Random segments with changing operation mixes and idle behavior.
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      send_mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
      recv_mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
      for (int i = 0; i < 100 && sent < RANDOM_ITEMS; i++) begin
        queue_item(rand_op(seg % 4), rand_key(), rand_value());
        sent++;
      end
      seg++;
    end

    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
